// ----- src/lobm_pkg.sv -----
// lobm_pkg: shared constants and the trade record type of the order book matcher
// used by limit_order_book_matcher_unit; depends on nothing
package lobm_pkg;

  localparam int MAX_ORDERS_DEF   = 64;
  localparam int PRICE_LEVELS_DEF = 1024;
  localparam int RESULT_CAP       = 64;

  localparam logic CMD_LIMIT  = 1'b0;
  localparam logic CMD_CANCEL = 1'b1;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_DROP    = 2'd1;
  localparam logic [1:0] STATUS_UNKNOWN = 2'd2;

  typedef struct packed {
    logic [63:0] trade_number;
    logic [31:0] buyer_key;
    logic [31:0] seller_key;
    logic [9:0]  trade_price;
    logic [31:0] trade_qty;
  } trade_t;

endpackage

// ----- src/lobm_ram.sv -----
// lobm_ram: generic single-port-write, single-port-read ram with registered read
// depends on nothing
module lobm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/limit_order_book_matcher_unit.sv -----
// limit_order_book_matcher_unit: price-time priority order book, sequencer and storage
// depends on lobm_pkg and lobm_ram
//
// One command is taken when start is high and busy is low; busy stays high until the
// command's last result has gone out. Results come on result_valid for one cycle each and
// cannot be held off; the final one carries last, the rested quantity, the best prices and
// the status. Resting orders live in a pool ram of MAX_ORDERS entries, price levels
// (head/tail of each level's fifo) in a second ram. The rate depends on the data and is set
// by the pool ram read port: every pass over the pool (cancel search, free slot search, and
// a best-price rebuild after a cancel or when a level empties) reads its MAX_ORDERS
// entries one by one. After reset both rams are swept, with busy high.
module limit_order_book_matcher_unit #(
  parameter int MAX_ORDERS   = lobm_pkg::MAX_ORDERS_DEF,
  parameter int PRICE_LEVELS = lobm_pkg::PRICE_LEVELS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        cmd,
  input  logic [31:0] order_key,
  input  logic        is_sell,
  input  logic [9:0]  limit_price,
  input  logic [31:0] order_qty,
  output logic        result_valid,
  output logic        trade_valid,
  output logic [63:0] trade_number,
  output logic [31:0] buyer_key,
  output logic [31:0] seller_key,
  output logic [9:0]  trade_price,
  output logic [31:0] trade_qty,
  output logic        last,
  output logic [31:0] rested_qty,
  output logic [9:0]  top_bid,
  output logic [9:0]  top_ask,
  output logic [1:0]  status
);

  localparam int SW     = $clog2(MAX_ORDERS);
  localparam int IW     = SW + 1;
  localparam int PW     = $clog2(PRICE_LEVELS);
  localparam int LW     = PW + 1;
  localparam int LDEPTH = 2 ** LW;
  localparam int CLR_N  = (LDEPTH > MAX_ORDERS) ? LDEPTH : MAX_ORDERS;
  localparam int CW     = $clog2(CLR_N + 1);
  localparam logic [IW-1:0] NIL = {1'b1, {SW{1'b0}}};

  typedef struct packed {
    logic          used;
    logic [31:0]   key;
    logic [31:0]   qty;
    logic [LW-1:0] ps;
    logic [IW-1:0] prev;
    logic [IW-1:0] nxt;
  } pool_word_t;

  typedef struct packed {
    logic [IW-1:0] head;
    logic [IW-1:0] tail;
  } level_word_t;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_SCAN, ST_CX_RD, ST_CX_PD, ST_CX_LV,
    ST_RM0, ST_RM1, ST_RM2, ST_RM_DONE, ST_MATCH, ST_M_LV, ST_M_PD,
    ST_REST, ST_ALLOC, ST_A_LV, ST_A_T, ST_FINISH
  } state_t;

  typedef enum logic [1:0] {RET_HIT, RET_BEST, RET_ALLOC} scan_ret_t;

  state_t           st;
  scan_ret_t        scan_ret;
  logic [CW-1:0]    clr_cnt;
  logic             cmd_r;
  logic [31:0]      key_r;
  logic             sell_r;
  logic [PW-1:0]    price_r;
  logic [31:0]      qty_r;
  logic [6:0]       n_r;
  logic [1:0]       status_r;
  logic [31:0]      rested_r;
  logic [PW-1:0]    bb;
  logic [PW-1:0]    ba;
  logic [63:0]      tcnt;
  logic             pend_v;
  lobm_pkg::trade_t pend;
  logic [IW-1:0]    cur_idx;
  pool_word_t       cur_d;
  logic [LW-1:0]    lv_r;
  level_word_t      lvd;
  logic [IW-1:0]    sc_addr;
  logic             sc_vld;
  logic [SW-1:0]    sc_idx;
  logic [PW-1:0]    acc_bid;
  logic [PW-1:0]    acc_ask;
  logic [IW-1:0]    acc_free;
  logic [IW-1:0]    acc_hit;

  logic             pool_we;
  logic [SW-1:0]    pool_waddr;
  pool_word_t       pool_wdata;
  logic [SW-1:0]    pool_raddr;
  pool_word_t       pool_rdata;
  logic             level_we;
  logic [LW-1:0]    level_waddr;
  level_word_t      level_wdata;
  logic [LW-1:0]    level_raddr;
  level_word_t      level_rdata;

  logic          limit_ok;
  logic [PW-1:0] best_opp;
  logic          crosses;
  logic          p_ok;
  logic          n_ok;
  logic [31:0]   fill;
  logic [31:0]   left;
  logic          scan_more;
  logic          cap_hit;

  lobm_ram #(.WIDTH($bits(pool_word_t)), .DEPTH(MAX_ORDERS)) u_pool (
    .clk(clk), .we(pool_we), .waddr(pool_waddr), .wdata(pool_wdata),
    .raddr(pool_raddr), .rdata(pool_rdata)
  );

  lobm_ram #(.WIDTH($bits(level_word_t)), .DEPTH(LDEPTH)) u_level (
    .clk(clk), .we(level_we), .waddr(level_waddr), .wdata(level_wdata),
    .raddr(level_raddr), .rdata(level_rdata)
  );

  assign busy      = (st != ST_IDLE);
  assign limit_ok  = (limit_price != 10'd0) && (32'(limit_price) < 32'(PRICE_LEVELS))
                     && (order_qty != 32'd0);
  assign best_opp  = sell_r ? bb : ba;
  assign crosses   = sell_r ? (price_r <= best_opp) : (price_r >= best_opp);
  assign p_ok      = !cur_d.prev[SW];
  assign n_ok      = !cur_d.nxt[SW];
  assign fill      = (qty_r < pool_rdata.qty) ? qty_r : pool_rdata.qty;
  assign left      = pool_rdata.qty - fill;
  assign scan_more = sc_addr < IW'(MAX_ORDERS);
  assign cap_hit   = (n_r == 7'(lobm_pkg::RESULT_CAP));

  // ram port control
  always_comb begin
    pool_we     = 1'b0;
    pool_waddr  = cur_idx[SW-1:0];
    pool_wdata  = cur_d;
    pool_raddr  = '0;
    level_we    = 1'b0;
    level_waddr = lv_r;
    level_wdata = '{head: NIL, tail: NIL};
    level_raddr = lv_r;
    unique case (st)
      ST_CLEAR: begin
        pool_we     = clr_cnt < CW'(MAX_ORDERS);
        pool_waddr  = clr_cnt[SW-1:0];
        pool_wdata  = '0;
        level_we    = clr_cnt < CW'(LDEPTH);
        level_waddr = clr_cnt[LW-1:0];
      end
      ST_SCAN:  pool_raddr = sc_addr[SW-1:0];
      ST_CX_RD: pool_raddr = cur_idx[SW-1:0];
      ST_CX_PD: level_raddr = pool_rdata.ps;
      ST_RM0: begin
        pool_we          = 1'b1;
        pool_wdata.used  = 1'b0;
        level_we         = 1'b1;
        level_wdata.head = p_ok ? lvd.head : cur_d.nxt;
        level_wdata.tail = n_ok ? lvd.tail : cur_d.prev;
        pool_raddr       = p_ok ? cur_d.prev[SW-1:0] : cur_d.nxt[SW-1:0];
      end
      ST_RM1: begin
        pool_we        = 1'b1;
        pool_waddr     = cur_d.prev[SW-1:0];
        pool_wdata     = pool_rdata;
        pool_wdata.nxt = cur_d.nxt;
        pool_raddr     = cur_d.nxt[SW-1:0];
      end
      ST_RM2: begin
        pool_we         = 1'b1;
        pool_waddr      = cur_d.nxt[SW-1:0];
        pool_wdata      = pool_rdata;
        pool_wdata.prev = cur_d.prev;
      end
      ST_MATCH: level_raddr = {~sell_r, best_opp};
      ST_M_LV:  pool_raddr = level_rdata.head[SW-1:0];
      ST_M_PD: begin
        pool_we        = (left != 32'd0);
        pool_wdata     = pool_rdata;
        pool_wdata.qty = left;
      end
      ST_ALLOC: level_raddr = {sell_r, price_r};
      ST_A_LV: begin
        level_we    = 1'b1;
        level_wdata = '{head: level_rdata.head[SW] ? cur_idx : level_rdata.head,
                        tail: cur_idx};
        pool_we     = 1'b1;
        pool_wdata  = '{used: 1'b1, key: key_r, qty: qty_r, ps: lv_r,
                        prev: level_rdata.head[SW] ? NIL : level_rdata.tail, nxt: NIL};
        pool_raddr  = level_rdata.tail[SW-1:0];
      end
      ST_A_T: begin
        pool_we        = 1'b1;
        pool_waddr     = lvd.tail[SW-1:0];
        pool_wdata     = pool_rdata;
        pool_wdata.nxt = cur_idx;
      end
      ST_IDLE, ST_CX_LV, ST_RM_DONE, ST_REST, ST_FINISH: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st           <= ST_CLEAR;
      clr_cnt      <= '0;
      result_valid <= 1'b0;
      pend_v       <= 1'b0;
      tcnt         <= '0;
      bb           <= '0;
      ba           <= '0;
      sc_vld       <= 1'b0;
    end else begin
      result_valid <= (st == ST_FINISH) || (st == ST_M_PD && pend_v);
      unique case (st)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == CW'(CLR_N - 1)) st <= ST_IDLE;
        end
        ST_IDLE: if (start) begin
          cmd_r    <= cmd;
          key_r    <= order_key;
          sell_r   <= is_sell;
          price_r  <= PW'(limit_price);
          qty_r    <= order_qty;
          n_r      <= '0;
          status_r <= lobm_pkg::STATUS_OK;
          rested_r <= '0;
          pend_v   <= 1'b0;
          if (cmd == lobm_pkg::CMD_CANCEL) begin
            sc_addr  <= '0;
            sc_vld   <= 1'b0;
            acc_bid  <= '0;
            acc_ask  <= '0;
            acc_free <= NIL;
            acc_hit  <= NIL;
            scan_ret <= RET_HIT;
            st       <= ST_SCAN;
          end else if (limit_ok) begin
            st <= ST_MATCH;
          end else begin
            st <= ST_FINISH;
          end
        end
        ST_SCAN: begin
          if (scan_more) begin
            sc_addr <= sc_addr + 1'b1;
            sc_idx  <= sc_addr[SW-1:0];
          end
          sc_vld <= scan_more;
          if (sc_vld) begin
            if (pool_rdata.used) begin
              if (!pool_rdata.ps[PW]) begin
                if (pool_rdata.ps[PW-1:0] > acc_bid) acc_bid <= pool_rdata.ps[PW-1:0];
              end else if (acc_ask == '0 || pool_rdata.ps[PW-1:0] < acc_ask) begin
                acc_ask <= pool_rdata.ps[PW-1:0];
              end
              // lowest matching slot wins
              if (pool_rdata.key == key_r && acc_hit[SW]) acc_hit <= {1'b0, sc_idx};
            end else if (acc_free[SW]) begin
              acc_free <= {1'b0, sc_idx};
            end
          end
          if (!scan_more && !sc_vld) begin
            unique case (scan_ret)
              RET_HIT: begin
                if (acc_hit[SW]) begin
                  status_r <= lobm_pkg::STATUS_UNKNOWN;
                  st       <= ST_FINISH;
                end else begin
                  cur_idx <= acc_hit;
                  st      <= ST_CX_RD;
                end
              end
              RET_BEST: begin
                bb <= acc_bid;
                ba <= acc_ask;
                st <= (cmd_r == lobm_pkg::CMD_CANCEL) ? ST_FINISH : ST_MATCH;
              end
              RET_ALLOC: begin
                bb <= acc_bid;
                ba <= acc_ask;
                if (acc_free[SW]) begin
                  status_r <= lobm_pkg::STATUS_DROP;
                  st       <= ST_FINISH;
                end else begin
                  cur_idx <= acc_free;
                  st      <= ST_ALLOC;
                end
              end
            endcase
          end
        end
        ST_CX_RD: st <= ST_CX_PD;
        ST_CX_PD: begin
          cur_d <= pool_rdata;
          lv_r  <= pool_rdata.ps;
          st    <= ST_CX_LV;
        end
        ST_CX_LV: begin
          lvd <= level_rdata;
          st  <= ST_RM0;
        end
        ST_RM0: begin
          if (p_ok) st <= ST_RM1;
          else if (n_ok) st <= ST_RM2;
          else st <= ST_RM_DONE;
        end
        ST_RM1: st <= n_ok ? ST_RM2 : ST_RM_DONE;
        ST_RM2: st <= ST_RM_DONE;
        ST_RM_DONE: begin
          // a cancel or an emptied level needs the best prices rebuilt
          if (cmd_r == lobm_pkg::CMD_CANCEL || (!p_ok && !n_ok)) begin
            sc_addr  <= '0;
            sc_vld   <= 1'b0;
            acc_bid  <= '0;
            acc_ask  <= '0;
            acc_free <= NIL;
            acc_hit  <= NIL;
            scan_ret <= RET_BEST;
            st       <= ST_SCAN;
          end else begin
            st <= ST_MATCH;
          end
        end
        ST_MATCH: begin
          if (qty_r == 32'd0 || cap_hit || best_opp == '0 || !crosses) begin
            st <= ST_REST;
          end else begin
            lv_r <= {~sell_r, best_opp};
            st   <= ST_M_LV;
          end
        end
        ST_M_LV: begin
          lvd     <= level_rdata;
          cur_idx <= level_rdata.head;
          st      <= level_rdata.head[SW] ? ST_REST : ST_M_PD;
        end
        ST_M_PD: begin
          cur_d             <= pool_rdata;
          tcnt              <= tcnt + 64'd1;
          pend_v            <= 1'b1;
          pend.trade_number <= tcnt + 64'd1;
          pend.buyer_key    <= sell_r ? pool_rdata.key : key_r;
          pend.seller_key   <= sell_r ? key_r : pool_rdata.key;
          pend.trade_price  <= 10'(lv_r[PW-1:0]);
          pend.trade_qty    <= fill;
          // the held trade is not the last one, send it now
          if (pend_v) begin
            trade_valid  <= 1'b1;
            trade_number <= pend.trade_number;
            buyer_key    <= pend.buyer_key;
            seller_key   <= pend.seller_key;
            trade_price  <= pend.trade_price;
            trade_qty    <= pend.trade_qty;
            last         <= 1'b0;
            rested_qty   <= '0;
            top_bid      <= '0;
            top_ask      <= '0;
            status       <= lobm_pkg::STATUS_OK;
          end
          qty_r <= qty_r - fill;
          n_r   <= n_r + 7'd1;
          st    <= (left != 32'd0) ? ST_MATCH : ST_RM0;
        end
        ST_REST: begin
          if (qty_r == 32'd0) begin
            st <= ST_FINISH;
          end else if (cap_hit && best_opp != '0 && crosses) begin
            status_r <= lobm_pkg::STATUS_DROP;
            st       <= ST_FINISH;
          end else begin
            sc_addr  <= '0;
            sc_vld   <= 1'b0;
            acc_bid  <= '0;
            acc_ask  <= '0;
            acc_free <= NIL;
            acc_hit  <= NIL;
            scan_ret <= RET_ALLOC;
            st       <= ST_SCAN;
          end
        end
        ST_ALLOC: begin
          lv_r <= {sell_r, price_r};
          st   <= ST_A_LV;
        end
        ST_A_LV: begin
          lvd      <= level_rdata;
          rested_r <= qty_r;
          if (sell_r) begin
            if (ba == '0 || price_r < ba) ba <= price_r;
          end else if (price_r > bb) begin
            bb <= price_r;
          end
          st <= level_rdata.head[SW] ? ST_FINISH : ST_A_T;
        end
        ST_A_T: st <= ST_FINISH;
        ST_FINISH: begin
          trade_valid  <= pend_v;
          trade_number <= pend_v ? pend.trade_number : '0;
          buyer_key    <= pend_v ? pend.buyer_key : '0;
          seller_key   <= pend_v ? pend.seller_key : '0;
          trade_price  <= pend_v ? pend.trade_price : '0;
          trade_qty    <= pend_v ? pend.trade_qty : '0;
          last         <= 1'b1;
          rested_qty   <= rested_r;
          top_bid      <= 10'(bb);
          top_ask      <= 10'(ba);
          status       <= status_r;
          pend_v       <= 1'b0;
          st           <= ST_IDLE;
        end
      endcase
    end
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted command did not raise busy");

  a_finish_last: assert property (@(posedge clk) disable iff (rst)
    (st == ST_FINISH) |=> (result_valid && last))
    else $error("command ended without a last beat");

  a_mid_is_trade: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !last) |-> (trade_valid && status == lobm_pkg::STATUS_OK
                                 && rested_qty == 32'd0))
    else $error("non-last beat without a trade");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (result_valid && last) |-> !busy)
    else $error("last beat while still busy");

endmodule
